// ----- rtl/core/ssm_pkg.sv -----
//------------------------------------------------------------------------------
// ssm_pkg: shared definitions of the substring search matcher
// Widths, register indexes, cell control and result types, and the case fold.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

	localparam int MAX_PAT    = 16;
	localparam int MAX_TEXT   = 65536;
	localparam int POS_W      = $clog2(MAX_TEXT + 1);
	localparam int OFF_W      = 16;
	localparam int LEN_W      = 5;
	localparam int SEL_W      = $clog2(MAX_PAT);
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FOLD = CFG_IDX_W'(3);

	typedef struct packed {
		logic shift;
		logic clear;
		logic fold;
		logic active;
	} cell_ctrl_t;

	typedef struct packed {
		logic [OFF_W-1:0] match_begin;
		logic [OFF_W-1:0] match_end;
	} result_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
		logic [7:0] r;
		r = b;
		if (fold && b >= 8'h61 && b <= 8'h7a) begin
			r = b - 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssm_if.sv -----
//------------------------------------------------------------------------------
// ssm_if: channel interfaces of the substring search matcher
// Text input, match output and configuration write channels.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssm_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ssm_match_if;
	logic                     valid;
	logic                     ready;
	logic [ssm_pkg::OFF_W-1:0] match_begin;
	logic [ssm_pkg::OFF_W-1:0] match_end;

	modport source (output valid, output match_begin, output match_end, input ready);
	modport sink (input valid, input match_begin, input match_end, output ready);
endinterface

interface ssm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ssm_pkg::CFG_IDX_W-1:0]  index;
	logic [ssm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ssm_cell.sv -----
//------------------------------------------------------------------------------
// ssm_cell: one window cell
// Holds one text byte of the window, hands it to the next cell on each beat
// and compares the incoming byte with its pattern byte.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssm_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire ssm_pkg::cell_ctrl_t ctrl,
	input  wire  [7:0]               data_in,
	input  wire  [7:0]               pat_byte,
	output logic [7:0]               win_q,
	output logic                     hit
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 8'h00;
		end else if (ctrl.shift) begin
			win_q <= ctrl.clear ? 8'h00 : data_in;
		end
	end

	assign hit = !ctrl.active ||
		(ssm_pkg::fold_byte(data_in, ctrl.fold) == ssm_pkg::fold_byte(pat_byte, ctrl.fold));

endmodule

`default_nettype wire

// ----- rtl/core/ssm_outbuf.sv -----
//------------------------------------------------------------------------------
// ssm_outbuf: match output register with skid stage
// Decouples the compare from a stalled receiver by one spare entry.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssm_outbuf (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire ssm_pkg::result_t res,
	output logic                  room,
	ssm_match_if.source           m
);

	logic             out_valid_q;
	logic             skid_valid_q;
	ssm_pkg::result_t out_q;
	ssm_pkg::result_t skid_q;
	logic             take;

	assign take = out_valid_q && m.ready;
	assign room = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && !take) begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && !take) begin
			skid_q <= res;
		end else begin
			out_q <= res;
		end
	end

	assign m.valid       = out_valid_q;
	assign m.match_begin = out_q.match_begin;
	assign m.match_end   = out_q.match_end;

endmodule

`default_nettype wire

// ----- rtl/core/substring_search_matcher.sv -----
//------------------------------------------------------------------------------
// substring_search_matcher: streaming non-overlapping substring search
// The text channel takes one byte per beat, with end_of_text on the last byte
// of a text. Each beat shifts the byte into a row of sixteen window cells;
// every cell compares its incoming byte with the pattern byte that lines up
// with it, and the row reports whether the newest pattern_length bytes equal
// the pattern, with optional ASCII case folding.
// A match leaves on the match channel from an output register, carrying begin
// and end offsets counted from zero within the text. Matches never overlap.
// Offsets saturate at MAX_TEXT, and later matches are dropped. Throughput is
// one byte per cycle while the skid stage is empty, set by the compare across
// the cell row and the offset check. The configuration channel is always
// ready; indexes 0 to 3 select the pattern words, the length and case fold.
// When the receiver stalls, one match waits in the output register and one
// more in a skid stage; the text channel stalls only once both are full.
// Reset clears the window, offsets, configuration and buffered matches.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module substring_search_matcher (
	input  wire          clk,
	input  wire          arst_n,
	ssm_cfg_if.sink      cfg,
	ssm_text_if.sink     text,
	ssm_match_if.source  match
);

	logic [63:0]                  pat_lo_q;
	logic [63:0]                  pat_hi_q;
	logic [ssm_pkg::LEN_W-1:0]    len_q;
	logic                         fold_q;
	logic [ssm_pkg::POS_W-1:0]    pos_q;
	logic [ssm_pkg::POS_W-1:0]    earliest_q;

	logic                         acc;
	logic                         room;
	logic [127:0]                 pat_all;
	logic [7:0]                   win   [ssm_pkg::MAX_PAT];
	logic [ssm_pkg::MAX_PAT-1:0]  cell_hit;
	logic                         len_ok;
	logic [ssm_pkg::POS_W:0]      pos_inc;
	logic [ssm_pkg::POS_W:0]      begin_pos;
	logic                         in_range;
	logic                         hit;
	ssm_pkg::result_t             res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
			fold_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				ssm_pkg::REG_PAT_LO: pat_lo_q <= cfg.data;
				ssm_pkg::REG_PAT_HI: pat_hi_q <= cfg.data;
				ssm_pkg::REG_PAT_LEN: len_q <= cfg.data[ssm_pkg::LEN_W-1:0];
				ssm_pkg::REG_FOLD: fold_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign acc        = text.valid && text.ready;
	assign text.ready = room;
	assign pat_all    = {pat_hi_q, pat_lo_q};

	genvar k;
	generate
		for (k = 0; k < ssm_pkg::MAX_PAT; k++) begin : g_cell
			ssm_pkg::cell_ctrl_t        ctrl;
			logic [ssm_pkg::SEL_W-1:0]  sel;
			logic [7:0]                 data_in;

			assign sel         = len_q[ssm_pkg::SEL_W-1:0] - ssm_pkg::SEL_W'(k + 1);
			assign ctrl.shift  = acc;
			assign ctrl.clear  = text.end_of_text;
			assign ctrl.fold   = fold_q;
			assign ctrl.active = len_q > ssm_pkg::LEN_W'(k);

			if (k == 0) begin : g_head
				assign data_in = text.text_byte;
			end else begin : g_body
				assign data_in = win[k-1];
			end

			ssm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.data_in  (data_in),
				.pat_byte (pat_all[8*sel +: 8]),
				.win_q    (win[k]),
				.hit      (cell_hit[k])
			);
		end
	endgenerate

	assign len_ok    = (len_q != '0) && (len_q <= ssm_pkg::LEN_W'(ssm_pkg::MAX_PAT));
	assign pos_inc   = {1'b0, pos_q} + (ssm_pkg::POS_W + 1)'(1);
	assign begin_pos = pos_inc - (ssm_pkg::POS_W + 1)'(len_q);
	assign in_range  = (pos_inc >= (ssm_pkg::POS_W + 1)'(len_q)) &&
		(pos_q < ssm_pkg::POS_W'(ssm_pkg::MAX_TEXT)) &&
		(begin_pos >= {1'b0, earliest_q});
	assign hit       = acc && len_ok && in_range && (&cell_hit);

	assign res.match_begin = begin_pos[ssm_pkg::OFF_W-1:0];
	assign res.match_end   = pos_q[ssm_pkg::OFF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			earliest_q <= '0;
		end else if (acc) begin
			if (text.end_of_text) begin
				pos_q      <= '0;
				earliest_q <= '0;
			end else begin
				if (pos_q < ssm_pkg::POS_W'(ssm_pkg::MAX_TEXT)) begin
					pos_q <= pos_inc[ssm_pkg::POS_W-1:0];
				end
				if (hit) begin
					earliest_q <= pos_inc[ssm_pkg::POS_W-1:0];
				end
			end
		end
	end

	ssm_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (hit),
		.res    (res),
		.room   (room),
		.m      (match)
	);

`ifndef SYNTH
	a_stall_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!text.ready |-> match.valid)
		else $error("text stalled with no match pending");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && text.end_of_text) |=> (pos_q == '0 && earliest_q == '0))
		else $error("end of text did not clear offsets");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= ssm_pkg::POS_W'(ssm_pkg::MAX_TEXT))
		else $error("byte offset beyond saturation");

	a_hit_moves_earliest: assert property (@(posedge clk) disable iff (!arst_n)
		(hit && !text.end_of_text) |=>
		(earliest_q == $past(pos_q) + ssm_pkg::POS_W'(1)))
		else $error("match did not advance the earliest begin");
`endif

endmodule

`default_nettype wire

// ----- verif/substring_search_matcher_tb.sv -----
//------------------------------------------------------------------------------
// substring_search_matcher_tb: self-checking bench of the substring matcher
// A short directed run covers empty and overlong patterns, short texts,
// overlapping occurrences, case folding, unused register indexes and a pattern
// change in the middle of a text. Random phases then vary the pattern, the
// length and the folding, with sender idling and receiver stalls. A long
// receiver hold fills the block until it stalls its input. A scoreboard
// predicts every match from the accepted beats and checks each match beat
// against the oldest prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_search_matcher_tb;

	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASE_ITEMS  = 120;
	localparam int SETTLE       = 8;
	localparam int MAX_PRINTS   = 100;

	class match_scoreboard;
		logic [7:0]                     window [ssm_pkg::MAX_PAT];
		logic [ssm_pkg::POS_W-1:0]      position;
		logic [ssm_pkg::POS_W-1:0]      earliest;
		logic [ssm_pkg::CFG_DATA_W-1:0] pat_lo;
		logic [ssm_pkg::CFG_DATA_W-1:0] pat_hi;
		logic [ssm_pkg::LEN_W-1:0]      pat_len;
		logic                           fold;
		ssm_pkg::result_t               pending [$];
		int                             errors;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			pat_len = '0;
			fold = 1'b0;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			foreach (window[i]) window[i] = 8'h00;
			position = '0;
			earliest = '0;
		endfunction

		function logic [7:0] upcase(input logic [7:0] b);
			if (fold && b >= 8'h61 && b <= 8'h7a) begin
				return b - 8'h20;
			end
			return b;
		endfunction

		function logic [7:0] pattern_at(input int i);
			return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
		endfunction

		function void write_reg(input logic [ssm_pkg::CFG_IDX_W-1:0] idx,
				input logic [ssm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ssm_pkg::REG_PAT_LO: pat_lo = data;
				ssm_pkg::REG_PAT_HI: pat_hi = data;
				ssm_pkg::REG_PAT_LEN: pat_len = data[ssm_pkg::LEN_W-1:0];
				ssm_pkg::REG_FOLD: fold = data[0];
				default: ;
			endcase
		endfunction

		function void note_byte(input logic [7:0] b, input logic eot);
			logic [ssm_pkg::POS_W-1:0] begin_off;
			int                        len;
			bit                        hit;
			ssm_pkg::result_t          r;
			len = pat_len;
			for (int i = ssm_pkg::MAX_PAT - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = b;
			if (len != 0 && len <= ssm_pkg::MAX_PAT && position + 1 >= len &&
					position < ssm_pkg::MAX_TEXT) begin
				begin_off = ssm_pkg::POS_W'(position + 1 - len);
				if (begin_off >= earliest) begin
					hit = 1'b1;
					for (int i = 0; i < len; i++) begin
						if (upcase(window[len-1-i]) != upcase(pattern_at(i))) hit = 1'b0;
					end
					if (hit) begin
						r.match_begin = begin_off[ssm_pkg::OFF_W-1:0];
						r.match_end = position[ssm_pkg::OFF_W-1:0];
						pending.push_back(r);
						earliest = position + ssm_pkg::POS_W'(1);
					end
				end
			end
			if (position < ssm_pkg::MAX_TEXT) position++;
			if (eot) clear_text();
		endfunction

		task report(input string msg);
			if (errors < MAX_PRINTS) $display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_match(input ssm_pkg::result_t got);
			ssm_pkg::result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected match %0d..%0d", got.match_begin, got.match_end));
			end else begin
				want = pending.pop_front();
				if (got.match_begin !== want.match_begin) begin
					report($sformatf("match_begin %0d, expected %0d",
						got.match_begin, want.match_begin));
				end
				if (got.match_end !== want.match_end) begin
					report($sformatf("match_end %0d, expected %0d",
						got.match_end, want.match_end));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ssm_cfg_if   cfg_if ();
	ssm_text_if  text_if ();
	ssm_match_if match_if ();

	match_scoreboard sb = new();

	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_request;
	int         items_sent;
	logic [7:0] pat_buf [ssm_pkg::MAX_PAT];

	substring_search_matcher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.text   (text_if),
		.match  (match_if)
	);

	always #1 clk = ~clk;

	initial begin
		#200000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		match_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				match_if.ready <= 1'b0;
			end else begin
				match_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : monitor
		ssm_pkg::result_t got;
		if (arst_n === 1'b1) begin
			if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
			if (text_if.valid && text_if.ready) begin
				sb.note_byte(text_if.text_byte, text_if.end_of_text);
			end
			if (match_if.valid === 1'b1 && match_if.ready) begin
				got.match_begin = match_if.match_begin;
				got.match_end = match_if.match_end;
				sb.check_match(got);
			end
		end
	end

	function automatic logic [7:0] vary_case(input logic [7:0] b);
		if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7a && $urandom_range(3) == 0) begin
			return b ^ 8'h20;
		end
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_byte <= b;
		text_if.end_of_text <= eot;
		do @(posedge clk); while (text_if.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_string(input string s, input logic eot_last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], eot_last && i == s.len() - 1);
		end
	endtask

	task automatic drain();
		text_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ssm_pkg::CFG_IDX_W-1:0] idx,
			input logic [ssm_pkg::CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
	endtask

	task automatic use_string(input string s);
		for (int i = 0; i < ssm_pkg::MAX_PAT; i++) begin
			pat_buf[i] = (i < s.len()) ? s[i] : 8'($urandom);
		end
	endtask

	task automatic write_pattern(input int len, input logic fold, input bit with_unused);
		logic [ssm_pkg::CFG_DATA_W-1:0] lo;
		logic [ssm_pkg::CFG_DATA_W-1:0] hi;
		logic [ssm_pkg::CFG_DATA_W-1:0] word;
		drain();
		for (int i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = pat_buf[i];
			hi[i*8 +: 8] = pat_buf[i+8];
		end
		cfg_write(ssm_pkg::REG_PAT_LO, lo);
		cfg_write(ssm_pkg::REG_PAT_HI, hi);
		word = {$urandom, $urandom};
		word[ssm_pkg::LEN_W-1:0] = ssm_pkg::LEN_W'(len);
		cfg_write(ssm_pkg::REG_PAT_LEN, word);
		word = {$urandom, $urandom};
		word[0] = fold;
		cfg_write(ssm_pkg::REG_FOLD, word);
		if (with_unused) begin
			cfg_write(ssm_pkg::CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
		end
		cfg_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int target;
		int phase;
		int plen;
		int span;
		int n;
		int r;
		arst_n <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		text_if.valid <= 1'b0;
		text_if.text_byte <= 8'h00;
		text_if.end_of_text <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run: the reset pattern is empty and finds nothing.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		use_string("aba");
		write_pattern(3, 1'b0, 1'b1);
		send_string("ab", 1'b1);
		send_string("ababa", 1'b1);
		write_pattern(3, 1'b1, 1'b0);
		send_string("ABA", 1'b1);
		use_string("a{");
		write_pattern(2, 1'b1, 1'b0);
		send_string("A[A{", 1'b1);
		use_string("a");
		write_pattern(17, 1'b0, 1'b0);
		send_byte("a", 1'b1);
		// The text stays open while the pattern changes underneath it.
		use_string("aba");
		write_pattern(3, 1'b0, 1'b0);
		send_string("xab", 1'b0);
		use_string("bc");
		write_pattern(2, 1'b0, 1'b1);
		send_byte("c", 1'b1);

		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 15;
					recv_stall_pct = 15;
				end
			endcase
			r = $urandom_range(99);
			if (r < 5) plen = 0;
			else if (r < 15) plen = ssm_pkg::MAX_PAT;
			else if (r < 20) plen = $urandom_range(ssm_pkg::MAX_PAT + 1, 31);
			else plen = $urandom_range(1, 6);
			r = $urandom_range(9);
			for (int i = 0; i < ssm_pkg::MAX_PAT; i++) begin
				if (r == 0) pat_buf[i] = 8'h00;
				else if (r == 1) pat_buf[i] = 8'hFF;
				else if ($urandom_range(9) < 7) pat_buf[i] = vary_case(8'(8'h61 + $urandom_range(3)));
				else pat_buf[i] = 8'($urandom);
			end
			write_pattern(plen, 1'($urandom_range(1)), $urandom_range(9) < 3);
			span = (plen >= 1 && plen <= ssm_pkg::MAX_PAT) ? plen : ssm_pkg::MAX_PAT;
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 35 && plen >= 1 && plen <= ssm_pkg::MAX_PAT) begin
					for (int i = 0; i < plen; i++) begin
						send_byte(vary_case(pat_buf[i]), $urandom_range(59) == 0);
					end
					n += plen;
				end else if (r < 80) begin
					send_byte(vary_case(pat_buf[$urandom_range(span - 1)]), $urandom_range(59) == 0);
					n++;
				end else begin
					send_byte(8'($urandom), $urandom_range(59) == 0);
					n++;
				end
			end
			phase++;
		end

		// Every byte matches while the receiver holds off, so the block backs up.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		use_string("x");
		write_pattern(1, 1'b0, 1'b0);
		hold_request = 200;
		for (int i = 0; i < PHASE_ITEMS; i++) send_byte("x", i == PHASE_ITEMS - 1);

		drain();
		if (sb.pending.size() != 0) begin
			sb.report($sformatf("%0d expected matches never arrived", sb.pending.size()));
		end
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
